/* rtl/plsa_pkg.sv */
// ============================================================================
// plsa_pkg
// Types and constants shared by the pair LOD score accumulator modules.
// ============================================================================
package plsa_pkg;

    // Width of the shared multiply-accumulate register.
    localparam int ACC_W = 96;
    // Operand and product widths of the shared multiplier.
    localparam int OPD_W = 33;
    localparam int PRD_W = 2 * OPD_W;

    // Fraction bits of each log2 and the number of squaring rounds.
    localparam int LOG2_FRAC = 20;
    // Leading-one position width (0 to ACC_W-1).
    localparam int LEAD_W    = 7;
    // Mantissa width of the normalized log2 argument (Q1.30).
    localparam int MANT_W    = 31;

    // log10(2) in Q0.32.
    localparam logic signed [OPD_W-1:0] LOG10_OF_2_Q32 = 33'sd1292913986;
    // Weight of the constant-one term of the numerator and denominator.
    localparam logic signed [OPD_W-1:0] UNIT_SCALE     = 33'sd131072;
    // Inverse of the lower bound on the ratio.
    localparam logic signed [OPD_W-1:0] RATIO_FLOOR_INV = 33'sd10000;

    // Q4.12 result limits.
    localparam logic signed [15:0] LOG_FLOOR = -16'sd16384;
    localparam logic signed [15:0] LOG_CLAMP = 16'sd1843;
    localparam logic signed [15:0] LOG_MAX   = 16'sd32767;

    // Pair kinds that need special handling.
    localparam logic [2:0] KIND_MAT_HSIB = 3'd2;
    localparam logic [2:0] KIND_PAT_HSIB = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LAMBDA_M = 2'd0,
        CFG_LAMBDA_P = 2'd1,
        CFG_LAMBDA_D = 2'd2,
        CFG_CLAMP    = 2'd3
    } t_cfg_idx;

    // Product alignment within the accumulator.
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } t_shift;

    // Command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic   mul;
        logic   acc;
        t_shift shift;
        logic   load;
    } t_mac_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NUM,
        ST_DEN,
        ST_LR,
        ST_CMP,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_UPD,
        ST_SCALE,
        ST_FIN
    } t_state;

endpackage

/* rtl/plsa_mac.sv */
// ============================================================================
// plsa_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ============================================================================
module plsa_mac
    import plsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_op                 i_op,
    input  logic [ACC_W-1:0]        i_load_val,
    input  logic signed [OPD_W-1:0] i_a,
    input  logic signed [OPD_W-1:0] i_b,
    output logic signed [PRD_W-1:0] o_prod,
    output logic [ACC_W-1:0]        o_acc
);

    logic signed [PRD_W-1:0] r_prod;
    logic                    r_pend;
    t_shift                  r_shift;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W-1:0]        addend;

    // Product pending flag for the accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_op.mul & i_op.acc;
        end
    end

    // Multiplier stage.
    always_ff @(posedge i_clk) begin
        if (i_op.mul) begin
            r_prod  <= i_a * i_b;
            r_shift <= i_op.shift;
        end
    end

    // Align the product to its place in the accumulator.
    always_comb begin
        prod_ext = {{(ACC_W-PRD_W){r_prod[PRD_W-1]}}, r_prod};
        unique case (r_shift)
            SH_0:    addend = prod_ext;
            SH_32:   addend = prod_ext << 32;
            SH_64:   addend = prod_ext << 64;
            default: addend = prod_ext;
        endcase
    end

    // Accumulate stage; a load takes precedence.
    always_ff @(posedge i_clk) begin
        if (i_op.load) begin
            r_acc <= i_load_val;
        end else if (r_pend) begin
            r_acc <= r_acc + addend;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

/* rtl/plsa_norm.sv */
// ============================================================================
// plsa_norm
// Leading-one normalizer: binary search over the word, one step per cycle.
// ============================================================================
module plsa_norm
    import plsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_x,
    output logic              o_done,
    output logic [MANT_W-1:0] o_mant,
    output logic [LEAD_W-1:0] o_lead
);

    localparam logic [2:0] LAST_STEP = 3'd6;

    logic [ACC_W-1:0]  r_x;
    logic [LEAD_W-1:0] r_lz;
    logic [2:0]        r_step;
    logic              r_busy;
    logic              r_done;
    logic [LEAD_W-1:0] step_size;
    logic [LEAD_W-1:0] rem_bits;
    logic              top_zero;

    // Try shifts of 64, 32, 16, 8, 4, 2 and 1 in turn.
    always_comb begin
        step_size = LEAD_W'(64) >> r_step;
        rem_bits  = LEAD_W'(ACC_W) - step_size;
        top_zero  = ((r_x >> rem_bits) == '0);
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shifting word and leading-zero count.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x  <= i_x;
            r_lz <= '0;
        end else if (r_busy && top_zero) begin
            r_x  <= r_x << step_size;
            r_lz <= r_lz + step_size;
        end
    end

    assign o_done = r_done;
    assign o_mant = r_x[ACC_W-1 -: MANT_W];
    assign o_lead = LEAD_W'(ACC_W - 1) - r_lz;

endmodule

/* rtl/pair_lod_score_accumulator.sv */
// ============================================================================
// pair_lod_score_accumulator
// Scores one relative pair per item as a log10 likelihood ratio and keeps
// the running marker total.
// ============================================================================
// One item is taken at a time and is worked on from acceptance until its
// result is registered; an item whose denominator is zero or whose ratio
// falls below the floor skips the log2 evaluations and finishes early.
// The schedule is set by the single shared 33x33 multiplier: the numerator,
// the denominator, the weighted ratio and the floor test take four, four,
// four and three products, and each of the two log2 evaluations takes
// twenty dependent squarings after a seven-step leading-one search. The
// result sits in an output register, so the next item is taken as soon as
// the sequencer is idle even while the previous result waits. The total is
// cleared after the item marked as the last pair.
// ============================================================================
module pair_lod_score_accumulator
    import plsa_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_share_zero,
    input  logic [15:0]        i_share_one,
    input  logic [15:0]        i_share_two,
    input  logic signed [16:0] i_share_parent_diff,
    input  logic [15:0]        i_prior_zero,
    input  logic [15:0]        i_prior_two,
    input  logic [15:0]        i_pair_weight,
    input  logic [2:0]         i_pair_kind,
    input  logic               i_last_pair,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_pair_log_ratio,
    output logic signed [31:0] o_lod_total,
    output logic               o_is_last
);

    localparam int ONE_I = 1 << PROB_FRAC_BITS;
    localparam int PF_W  = ((PROB_FRAC_BITS > 17) ? PROB_FRAC_BITS : 17) + 3;
    localparam logic [4:0] SQ_LAST = 5'(LOG2_FRAC - 1);

    // Configuration registers.
    logic [23:0] r_lm;
    logic [23:0] r_lp;
    logic [23:0] r_l2;
    logic        r_clamp;

    // Captured item.
    logic [15:0]        r_f0;
    logic [15:0]        r_f1;
    logic [15:0]        r_f2;
    logic signed [16:0] r_d;
    logic [15:0]        r_pf0;
    logic [15:0]        r_pf2;
    logic [15:0]        r_w;
    logic [2:0]         r_kind;
    logic               r_last;

    // Sequencer and intermediate values.
    t_state                   r_state;
    t_state                   n_state;
    logic [4:0]               r_cnt;
    logic [4:0]               n_cnt;
    logic                     r_which;
    logic signed [63:0]       r_num;
    logic signed [63:0]       r_den;
    logic [ACC_W-1:0]         r_n;
    logic [MANT_W-1:0]        r_m;
    logic [LOG2_FRAC-1:0]     r_frac;
    logic [LOG2_FRAC-1:0]     r_fn;
    logic [LOG2_FRAC-1:0]     r_fd;
    logic [LEAD_W-1:0]        r_kn;
    logic [LEAD_W-1:0]        r_kd;
    logic signed [15:0]       r_ratio;
    logic signed [31:0]       r_lod;

    // Output register.
    logic                     r_out_valid;
    logic signed [15:0]       r_out_ratio;
    logic signed [31:0]       r_out_total;
    logic                     r_out_last;

    // Shared unit connections.
    t_mac_op                  mac_op;
    logic [ACC_W-1:0]         load_val;
    logic signed [OPD_W-1:0]  mac_a;
    logic signed [OPD_W-1:0]  mac_b;
    logic signed [PRD_W-1:0]  mac_prod;
    logic [ACC_W-1:0]         mac_acc;
    logic                     norm_start;
    logic [ACC_W-1:0]         norm_x;
    logic                     norm_done;
    logic [MANT_W-1:0]        norm_mant;
    logic [LEAD_W-1:0]        norm_lead;

    // Derived operands.
    logic                     sib;
    logic signed [17:0]       a_mat;
    logic signed [17:0]       a_pat;
    logic signed [PF_W-1:0]   pf1;
    logic signed [PF_W-1:0]   b_mat;
    logic signed [PF_W-1:0]   b_pat;
    logic                     den_neg;
    logic [63:0]              den_abs;
    logic [ACC_W-1:0]         ud_ext;
    logic signed [16:0]       ws;
    logic signed [PF_W-1:0]   omw;
    logic signed [PF_W-1:0]   vs;
    logic                     n_pos;
    logic [31:0]              sq_p;
    logic [MANT_W-1:0]        sq_m;
    logic [LOG2_FRAC-1:0]     sq_frac;
    logic signed [8:0]        kdiff;
    logic signed [29:0]       l2v;
    logic signed [20:0]       rq;
    logic                     out_free;
    logic signed [15:0]       ratio_c;
    logic signed [32:0]       sum_w;
    logic signed [31:0]       sum_sat;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lm    <= 24'd65536;
            r_lp    <= 24'd65536;
            r_l2    <= 24'd65536;
            r_clamp <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LAMBDA_M: r_lm    <= i_cfg_data;
                CFG_LAMBDA_P: r_lp    <= i_cfg_data;
                CFG_LAMBDA_D: r_l2    <= i_cfg_data;
                CFG_CLAMP:    r_clamp <= i_cfg_data[0];
                default:      r_clamp <= r_clamp;
            endcase
        end
    end

    // Operands of the numerator and denominator terms.
    always_comb begin
        sib   = (r_kind < KIND_OTHER);
        a_mat = sib ? $signed({2'b00, r_f1}) + 18'(r_d) : $signed({2'b00, r_f1});
        a_pat = sib ? $signed({2'b00, r_f1}) - 18'(r_d) : $signed({2'b00, r_f1});
        pf1   = $signed(PF_W'(ONE_I)) - $signed(PF_W'(r_pf0)) - $signed(PF_W'(r_pf2));
        if (r_kind == KIND_MAT_HSIB) begin
            b_mat = pf1 <<< 1;
            b_pat = '0;
        end else if (r_kind == KIND_PAT_HSIB) begin
            b_mat = '0;
            b_pat = pf1 <<< 1;
        end else begin
            b_mat = pf1;
            b_pat = pf1;
        end
    end

    // Sign handling of the ratio and the floor test operands.
    always_comb begin
        den_neg = r_den[63];
        den_abs = den_neg ? 64'(-r_den) : 64'(r_den);
        ud_ext  = {{(ACC_W-64){1'b0}}, den_abs};
        omw     = $signed(PF_W'(ONE_I)) - $signed(PF_W'(r_w));
        ws      = den_neg ? -$signed({1'b0, r_w}) : $signed({1'b0, r_w});
        vs      = den_neg ? -omw : omw;
        n_pos   = !mac_acc[ACC_W-1] && (mac_acc != '0);
    end

    // One squaring round of the log2 fraction.
    always_comb begin
        sq_p    = mac_prod[61:30];
        sq_m    = sq_p[31] ? sq_p[31:1] : sq_p[30:0];
        sq_frac = {r_frac[LOG2_FRAC-2:0], sq_p[31]};
    end

    // log2 of the ratio and its rounded log10.
    always_comb begin
        kdiff = $signed({2'b00, r_kn}) - $signed({2'b00, r_kd})
                - $signed(9'(PROB_FRAC_BITS));
        l2v   = ($signed(30'(kdiff)) <<< LOG2_FRAC)
                + $signed({10'b0, r_fn}) - $signed({10'b0, r_fd});
        rq    = $signed(mac_acc[60:40]);
    end

    // Final clamp and saturating total.
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        ratio_c  = (r_clamp && (r_ratio > LOG_CLAMP)) ? LOG_CLAMP : r_ratio;
        sum_w    = 33'(r_lod) + 33'(ratio_c);
        if (sum_w > 33'sd2147483647) begin
            sum_sat = 32'sh7FFFFFFF;
        end else if (sum_w < -33'sd2147483648) begin
            sum_sat = 32'sh80000000;
        end else begin
            sum_sat = sum_w[31:0];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sequencer: next state and commands to the shared units.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt + 5'd1;
        mac_op     = '{mul: 1'b0, acc: 1'b0, shift: SH_0, load: 1'b0};
        load_val   = '0;
        mac_a      = '0;
        mac_b      = '0;
        norm_start = 1'b0;
        norm_x     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state     = ST_NUM;
                    mac_op.load = 1'b1;
                end
            end
            ST_NUM: begin
                if (r_cnt < 5'd4) begin
                    mac_op.mul = 1'b1;
                    mac_op.acc = 1'b1;
                    unique case (r_cnt[1:0])
                        2'd0: begin mac_a = OPD_W'(r_f0); mac_b = UNIT_SCALE; end
                        2'd1: begin mac_a = OPD_W'(a_mat); mac_b = OPD_W'(r_lm); end
                        2'd2: begin mac_a = OPD_W'(a_pat); mac_b = OPD_W'(r_lp); end
                        default: begin
                            mac_a = OPD_W'({r_f2, 1'b0});
                            mac_b = OPD_W'(r_l2);
                        end
                    endcase
                end
                if (r_cnt == 5'd5) begin
                    n_state     = ST_DEN;
                    n_cnt       = '0;
                    mac_op.load = 1'b1;
                end
            end
            ST_DEN: begin
                if (r_cnt < 5'd4) begin
                    mac_op.mul = 1'b1;
                    mac_op.acc = 1'b1;
                    unique case (r_cnt[1:0])
                        2'd0: begin mac_a = OPD_W'(r_pf0); mac_b = UNIT_SCALE; end
                        2'd1: begin mac_a = OPD_W'(b_mat); mac_b = OPD_W'(r_lm); end
                        2'd2: begin mac_a = OPD_W'(b_pat); mac_b = OPD_W'(r_lp); end
                        default: begin
                            mac_a = OPD_W'({r_pf2, 1'b0});
                            mac_b = OPD_W'(r_l2);
                        end
                    endcase
                end
                if (r_cnt == 5'd5) begin
                    n_cnt       = '0;
                    mac_op.load = 1'b1;
                    n_state     = (mac_acc[63:0] == '0) ? ST_FIN : ST_LR;
                end
            end
            ST_LR: begin
                if (r_cnt < 5'd4) begin
                    mac_op.mul = 1'b1;
                    mac_op.acc = 1'b1;
                    unique case (r_cnt[1:0])
                        2'd0: begin
                            mac_a = OPD_W'(ws);
                            mac_b = $signed({1'b0, r_num[31:0]});
                        end
                        2'd1: begin
                            mac_a        = OPD_W'(ws);
                            mac_b        = OPD_W'($signed(r_num[63:32]));
                            mac_op.shift = SH_32;
                        end
                        2'd2: begin
                            mac_a = OPD_W'(vs);
                            mac_b = $signed({1'b0, r_den[31:0]});
                        end
                        default: begin
                            mac_a        = OPD_W'(vs);
                            mac_b        = OPD_W'($signed(r_den[63:32]));
                            mac_op.shift = SH_32;
                        end
                    endcase
                end
                if (r_cnt == 5'd5) begin
                    n_cnt = '0;
                    if (n_pos) begin
                        n_state     = ST_CMP;
                        mac_op.load = 1'b1;
                        load_val    = ACC_W'(-(ud_ext << PROB_FRAC_BITS));
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_CMP: begin
                if (r_cnt < 5'd3) begin
                    mac_op.mul = 1'b1;
                    mac_op.acc = 1'b1;
                    mac_b      = RATIO_FLOOR_INV;
                    unique case (r_cnt[1:0])
                        2'd0: mac_a = $signed({1'b0, r_n[31:0]});
                        2'd1: begin
                            mac_a        = $signed({1'b0, r_n[63:32]});
                            mac_op.shift = SH_32;
                        end
                        default: begin
                            mac_a        = $signed({1'b0, r_n[95:64]});
                            mac_op.shift = SH_64;
                        end
                    endcase
                end
                if (r_cnt == 5'd4) begin
                    n_cnt = '0;
                    if (mac_acc[ACC_W-1]) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state    = ST_NORM;
                        norm_start = 1'b1;
                    end
                end
            end
            ST_NORM: begin
                n_cnt = '0;
                if (norm_done) begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                n_cnt      = r_cnt;
                n_state    = ST_SQ_UPD;
                mac_op.mul = 1'b1;
                mac_a      = $signed({2'b00, r_m});
                mac_b      = $signed({2'b00, r_m});
            end
            ST_SQ_UPD: begin
                if (r_cnt == SQ_LAST) begin
                    n_cnt = '0;
                    if (!r_which) begin
                        n_state    = ST_NORM;
                        norm_start = 1'b1;
                        norm_x     = ud_ext;
                    end else begin
                        n_state = ST_SCALE;
                    end
                end else begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SCALE: begin
                if (r_cnt == 5'd0) begin
                    mac_op.mul  = 1'b1;
                    mac_op.acc  = 1'b1;
                    mac_op.load = 1'b1;
                    load_val    = ACC_W'(1) << 39;
                    mac_a       = OPD_W'(l2v);
                    mac_b       = LOG10_OF_2_Q32;
                end
                if (r_cnt == 5'd2) begin
                    n_cnt   = '0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_cnt = '0;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // Item capture and intermediate results.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_f0   <= i_share_zero;
            r_f1   <= i_share_one;
            r_f2   <= i_share_two;
            r_d    <= i_share_parent_diff;
            r_pf0  <= i_prior_zero;
            r_pf2  <= i_prior_two;
            r_w    <= i_pair_weight;
            r_kind <= i_pair_kind;
            r_last <= i_last_pair;
        end
        if (r_state == ST_NUM && r_cnt == 5'd5) begin
            r_num <= $signed(mac_acc[63:0]);
        end
        if (r_state == ST_DEN && r_cnt == 5'd5) begin
            r_den   <= $signed(mac_acc[63:0]);
            r_ratio <= LOG_FLOOR;
        end
        if (r_state == ST_LR && r_cnt == 5'd5) begin
            r_n <= mac_acc;
        end
        if (r_state == ST_NORM && norm_done) begin
            r_m    <= norm_mant;
            r_frac <= '0;
            if (!r_which) begin
                r_kn <= norm_lead;
            end else begin
                r_kd <= norm_lead;
            end
        end
        if (r_state == ST_SQ_UPD) begin
            r_m    <= sq_m;
            r_frac <= sq_frac;
            if (r_cnt == SQ_LAST) begin
                if (!r_which) begin
                    r_fn <= sq_frac;
                end else begin
                    r_fd <= sq_frac;
                end
            end
        end
        if (r_state == ST_SCALE && r_cnt == 5'd2) begin
            if (rq < 21'(LOG_FLOOR)) begin
                r_ratio <= LOG_FLOOR;
            end else if (rq > 21'(LOG_MAX)) begin
                r_ratio <= LOG_MAX;
            end else begin
                r_ratio <= rq[15:0];
            end
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_ratio <= ratio_c;
            r_out_total <= sum_sat;
            r_out_last  <= r_last;
        end
    end

    // Control: log2 operand select, running total and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_which     <= 1'b0;
            r_lod       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_IDLE) begin
                r_which <= 1'b0;
            end else if (r_state == ST_SQ_UPD && r_cnt == SQ_LAST) begin
                r_which <= 1'b1;
            end
            if (r_state == ST_FIN && out_free) begin
                r_lod       <= r_last ? '0 : sum_sat;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiply-accumulate unit.
    plsa_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (mac_op),
        .i_load_val (load_val),
        .i_a        (mac_a),
        .i_b        (mac_b),
        .o_prod     (mac_prod),
        .o_acc      (mac_acc)
    );

    // Leading-one normalizer for the log2 arguments.
    plsa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_x     (norm_x),
        .o_done  (norm_done),
        .o_mant  (norm_mant),
        .o_lead  (norm_lead)
    );

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_pair_log_ratio = r_out_ratio;
    assign o_lod_total      = r_out_total;
    assign o_is_last        = r_out_last;

`ifndef SYNTHESIS
    // The sequencer takes no second item in the cycle after one is accepted.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while the sequencer was busy");

    // A delivered ratio never lies below the floor.
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pair_log_ratio >= LOG_FLOOR))
        else $error("pair ratio below the floor");

    // With clamping on, a delivered ratio never exceeds the cap.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_clamp) |-> (o_pair_log_ratio <= LOG_CLAMP))
        else $error("pair ratio above the clamp");

    // The normalizer only finishes while the sequencer waits for it.
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done |-> (r_state == ST_NORM))
        else $error("normalizer finished outside its wait state");

    // After the last pair is delivered the running total is clear.
    a_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (r_lod == '0))
        else $error("running total not cleared after the last pair");
`endif

endmodule
